FILE: sv/glcm_pkg.sv
// Package: shared types and codes for the co-occurrence matrix core.
`timescale 1ns / 1ps
`default_nettype none
package glcm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_RANGE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DIR    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_WAIT,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_CNT_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pixel;
    logic [7:0] level_a;
    logic [7:0] level_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] entry_count;
    logic [8:0]  level_count;
    logic [7:0]  lowest_level;
  } out_item_t;

  // Sequencer to matrix memory: one access per cycle.
  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [15:0] wdata;
  } cnt_req_t;

endpackage
`default_nettype wire

FILE: sv/gray_level_cooccurrence_matrix_core.sv
// Top level: co-occurrence matrix core with sequencer, config port and memories.
// Usage:
//   in_ channel (valid/stall) carries commands: load pixel, compute, read entry,
//   restart. out_ channel carries one result per compute or read.
//   Load and restart give no result.
//   Compute clears the matrix, then walks every pixel with its neighbour:
//   each position passes FETCH_A, FETCH_B and WAIT, and each counted pair
//   adds two read-modify-write passes on the single matrix port.
//   A read passes READ and READ_WAIT to OUT, which fills the output register.
//   in_stall stays high while a command is in work or a result waits in the
//   output register; out_valid holds the result until taken, and while it
//   waits nothing new is accepted.
//   Reset empties the image count, sets min 255, max 0, level count 0, lowest
//   level 1 and the registers to 128, 128, 0. The matrix needs no clearing
//   pass at reset: a read before any compute finds a level count of zero.
//   Configuration writes via the cfg_ APB port at byte addresses 0, 4, 8.
`timescale 1ns / 1ps
`default_nettype none
module gray_level_cooccurrence_matrix_core #(
  parameter int unsigned MAX_WIDTH   = 128,
  parameter int unsigned MAX_HEIGHT  = 128,
  parameter int unsigned GRAY_LEVELS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire glcm_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output glcm_pkg::out_item_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [3:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  localparam int unsigned IAW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned LB  = $clog2(GRAY_LEVELS);
  localparam int unsigned CAW = 2 * LB;
  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // configuration
  logic [7:0] width_r, height_r;
  logic [1:0] dir_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      dir_r    <= glcm_pkg::DIR_0;
    end else if (cfg_wr) begin
      unique case (glcm_pkg::reg_idx_t'(cfg_paddr[3:2]))
        glcm_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[7:0];
        glcm_pkg::REG_HEIGHT: height_r <= cfg_pwdata[7:0];
        glcm_pkg::REG_DIR:    dir_r    <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (glcm_pkg::reg_idx_t'(cfg_paddr[3:2]))
      glcm_pkg::REG_WIDTH:  cfg_prdata = {24'd0, width_r};
      glcm_pkg::REG_HEIGHT: cfg_prdata = {24'd0, height_r};
      glcm_pkg::REG_DIR:    cfg_prdata = {30'd0, dir_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // clamped dimensions
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    if (width_r == 8'd0) w_eff = CW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    if (height_r == 8'd0) h_eff = RW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(height_r);
  end

  // state
  glcm_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    load_pos_r, cap;
  logic [7:0]       min_r, max_r, base_r;
  logic [8:0]       levels_r;
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    col_r;
  logic [CAW:0]     clr_r;
  logic [7:0]       pa_r, pb_r;
  logic             second_r;
  logic [7:0]       la_r, lb_r;
  logic             out_valid_r;
  glcm_pkg::out_item_t out_r;

  glcm_pkg::in_item_t in_d;
  assign in_d = in_data;
  logic acc;
  assign in_stall = (state_r != glcm_pkg::ST_IDLE) | out_valid_r;
  assign acc = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // image store capacity for the dimensions in force now
  assign cap = PW'(w_eff * h_eff);

  // neighbour position
  logic signed [RW+1:0] nr;
  logic signed [CW+1:0] nc;
  logic                 nb_ok;
  always_comb begin
    nr = $signed({2'b00, row_r});
    nc = $signed({2'b00, col_r});
    unique case (glcm_pkg::dir_t'(dir_r))
      glcm_pkg::DIR_0:   nc = nc + (CW+2)'(1);
      glcm_pkg::DIR_45:  begin nr = nr - (RW+2)'(1); nc = nc + (CW+2)'(1); end
      glcm_pkg::DIR_90:  nr = nr - (RW+2)'(1);
      glcm_pkg::DIR_135: begin nr = nr - (RW+2)'(1); nc = nc - (CW+2)'(1); end
      default: ;
    endcase
    nb_ok = (nr >= 0) && (nc >= 0) && (nr < $signed({2'b00, h_eff}))
            && (nc < $signed({2'b00, w_eff}));
  end

  // raster address: row * width + column, one small product
  logic [IAW-1:0] ra_own, ra_nb;
  assign ra_own = IAW'(row_r * w_eff + col_r);
  assign ra_nb  = IAW'($unsigned(nr[RW:0]) * w_eff + $unsigned(nc[CW:0]));

  // image memory
  logic           img_we;
  logic [IAW-1:0] img_raddr;
  logic [7:0]     img_rdata;
  assign img_we = acc && (glcm_pkg::op_t'(in_d.operation) == glcm_pkg::OP_LOAD)
                  && (load_pos_r < cap);
  assign img_raddr = (state_r == glcm_pkg::ST_FETCH_A) ? ra_own : ra_nb;

  glcm_image #(.AW(IAW)) u_image (
    .clk(clk), .we(img_we), .waddr(IAW'(load_pos_r)), .wdata(in_d.pixel),
    .raddr(img_raddr), .rdata(img_rdata)
  );

  // pair qualification
  logic [7:0] da, db;
  logic       pair_ok;
  assign da = pa_r - base_r;
  assign db = img_rdata - base_r;
  assign pair_ok = (pa_r != 8'd0) && (img_rdata != 8'd0) && (pa_r >= base_r)
                   && (img_rdata >= base_r) && ({1'b0, da} < levels_r)
                   && ({1'b0, db} < levels_r);

  // count memory
  glcm_pkg::cnt_req_t cnt_req;
  logic [15:0]        cnt_rdata;
  logic [CAW-1:0]     pair_addr;
  assign pair_addr = second_r ? {lb_r[LB-1:0], la_r[LB-1:0]}
                              : {la_r[LB-1:0], lb_r[LB-1:0]};
  always_comb begin
    cnt_req = '0;
    unique case (state_r)
      glcm_pkg::ST_CLEAR: begin
        cnt_req.wr   = 1'b1;
        cnt_req.addr = 16'(clr_r[CAW-1:0]);
      end
      glcm_pkg::ST_CNT_RD, glcm_pkg::ST_CNT_WAIT:
        cnt_req.addr = 16'(pair_addr);
      glcm_pkg::ST_CNT_WR: begin
        cnt_req.wr    = 1'b1;
        cnt_req.addr  = 16'(pair_addr);
        cnt_req.wdata = (cnt_rdata == 16'hFFFF) ? cnt_rdata : cnt_rdata + 16'd1;
      end
      default: cnt_req.addr = 16'({la_r[LB-1:0], lb_r[LB-1:0]});
    endcase
  end

  glcm_counts #(.AW(CAW)) u_counts (.clk(clk), .req(cnt_req), .rdata(cnt_rdata));

  logic last_pos;
  assign last_pos = (row_r == h_eff - RW'(1)) && (col_r == w_eff - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glcm_pkg::ST_IDLE:
        if (acc) begin
          unique case (glcm_pkg::op_t'(in_d.operation))
            glcm_pkg::OP_COMPUTE: state_nxt = glcm_pkg::ST_CLEAR;
            glcm_pkg::OP_READ:    state_nxt = glcm_pkg::ST_READ;
            default:              state_nxt = glcm_pkg::ST_IDLE;
          endcase
        end
      glcm_pkg::ST_CLEAR:
        if (clr_r[CAW-1:0] == '1) state_nxt = glcm_pkg::ST_FETCH_A;
      glcm_pkg::ST_FETCH_A: state_nxt = glcm_pkg::ST_FETCH_B;
      glcm_pkg::ST_FETCH_B: state_nxt = glcm_pkg::ST_WAIT;
      glcm_pkg::ST_WAIT:
        if (nb_ok && pair_ok) state_nxt = glcm_pkg::ST_CNT_RD;
        else if (last_pos) state_nxt = glcm_pkg::ST_OUT;
        else state_nxt = glcm_pkg::ST_FETCH_A;
      glcm_pkg::ST_CNT_RD:   state_nxt = glcm_pkg::ST_CNT_WAIT;
      glcm_pkg::ST_CNT_WAIT: state_nxt = glcm_pkg::ST_CNT_WR;
      glcm_pkg::ST_CNT_WR:
        if (!second_r) state_nxt = glcm_pkg::ST_CNT_RD;
        else if (last_pos) state_nxt = glcm_pkg::ST_OUT;
        else state_nxt = glcm_pkg::ST_FETCH_A;
      glcm_pkg::ST_READ:      state_nxt = glcm_pkg::ST_READ_WAIT;
      glcm_pkg::ST_READ_WAIT: state_nxt = glcm_pkg::ST_OUT;
      glcm_pkg::ST_OUT:       state_nxt = glcm_pkg::ST_IDLE;
      default:                state_nxt = glcm_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  logic [7:0] base_nxt;
  logic [8:0] span;
  assign base_nxt = (min_r == 8'd0) ? 8'd1 : min_r;
  assign span = {1'b0, max_r} - {1'b0, base_nxt} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glcm_pkg::ST_IDLE;
      load_pos_r  <= '0;
      min_r       <= 8'd255;
      max_r       <= 8'd0;
      base_r      <= 8'd1;
      levels_r    <= 9'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (acc) begin
        unique case (glcm_pkg::op_t'(in_d.operation))
          glcm_pkg::OP_LOAD:
            if (load_pos_r < cap) begin
              load_pos_r <= load_pos_r + PW'(1);
              if (in_d.pixel < min_r) min_r <= in_d.pixel;
              if (in_d.pixel > max_r) max_r <= in_d.pixel;
            end
          glcm_pkg::OP_RESTART: begin
            load_pos_r <= '0;
            min_r      <= 8'd255;
            max_r      <= 8'd0;
          end
          glcm_pkg::OP_COMPUTE: begin
            base_r <= base_nxt;
            if (max_r < base_nxt) levels_r <= 9'd0;
            else if (32'(span) > GRAY_LEVELS) levels_r <= 9'(GRAY_LEVELS);
            else levels_r <= span;
          end
          default: ;
        endcase
      end
      if (state_r == glcm_pkg::ST_OUT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      glcm_pkg::ST_IDLE: begin
        clr_r    <= '0;
        row_r    <= '0;
        col_r    <= '0;
        second_r <= 1'b0;
        la_r     <= in_d.level_a;
        lb_r     <= in_d.level_b;
        // hold the waiting result; take the kind only from a transfer
        if (acc) begin
          out_r.result_kind <= (glcm_pkg::op_t'(in_d.operation) == glcm_pkg::OP_COMPUTE)
                               ? glcm_pkg::KIND_DONE : glcm_pkg::KIND_ENTRY;
        end
      end
      glcm_pkg::ST_CLEAR: clr_r <= clr_r + (CAW+1)'(1);
      glcm_pkg::ST_FETCH_B: pa_r <= img_rdata;
      glcm_pkg::ST_WAIT: begin
        la_r     <= da;
        lb_r     <= db;
        second_r <= 1'b0;
        if (!(nb_ok && pair_ok)) begin
          if (col_r == w_eff - CW'(1)) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
          end else col_r <= col_r + CW'(1);
        end
      end
      glcm_pkg::ST_CNT_WR: begin
        second_r <= 1'b1;
        if (second_r) begin
          if (col_r == w_eff - CW'(1)) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
          end else col_r <= col_r + CW'(1);
        end
      end
      glcm_pkg::ST_OUT: begin
        out_r.level_count  <= levels_r;
        out_r.lowest_level <= base_r;
        if (out_r.result_kind == glcm_pkg::KIND_DONE) begin
          out_r.entry_count <= 16'd0;
        end else if ({1'b0, la_r} < levels_r && {1'b0, lb_r} < levels_r) begin
          out_r.result_kind <= glcm_pkg::KIND_ENTRY;
          out_r.entry_count <= cnt_rdata;
        end else begin
          out_r.result_kind <= glcm_pkg::KIND_RANGE;
          out_r.entry_count <= 16'd0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/glcm_counts.sv
// Pair-count memory: one read or write port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module glcm_counts #(
  parameter int unsigned AW = 16
) (
  input  wire logic                clk,
  input  wire glcm_pkg::cnt_req_t  req,
  output logic [15:0]              rdata
);
  logic [15:0] mem [2**AW];
  logic [AW-1:0] a;
  assign a = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[a] <= req.wdata;
    end
    rdata <= mem[a];
  end
endmodule
`default_nettype wire

FILE: sv/glcm_image.sv
// Image memory: one write and one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module glcm_image #(
  parameter int unsigned AW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/glcm_checker.sv
// Checker: port-level properties of the co-occurrence core, and its bind.
`timescale 1ns / 1ps
`default_nettype none
module glcm_assertions (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire glcm_pkg::out_item_t out_data,
  input wire logic                out_valid,
  input wire logic                out_stall
);
  // a waiting result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing is taken while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open with result pending");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_kind <= glcm_pkg::KIND_RANGE)
    else $error("bad result kind");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == glcm_pkg::KIND_RANGE
    |-> out_data.entry_count == '0)
    else $error("range result with count");
endmodule

bind gray_level_cooccurrence_matrix_core glcm_assertions u_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
`default_nettype wire
